// File: design/grid_min_path_sum_macros.svh
// Assertion macros shared by the grid minimum path sum design.
`ifndef GRID_MIN_PATH_SUM_MACROS_SVH
`define GRID_MIN_PATH_SUM_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside reset.
`define GMPS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GMPS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GMPS_ASSERT(name, clk, rst, prop, msg)
`define GMPS_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: design/gmps_pkg.sv
// Shared constants and types of the grid minimum path sum design.
`default_nettype none

package gmps_pkg;

   localparam int DEF_MAX_COLUMNS = 64;
   localparam int DEF_SUM_BITS    = 24;
   localparam int DEF_COST_BITS   = 10;

   localparam int ROWS_BITS      = 11;
   localparam int COLS_BITS      = 7;
   localparam int ROW_INDEX_BITS = 10;
   localparam int ROW_LIMIT      = 1024;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_ROWS    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_COLUMNS = 2'd1;

   localparam logic [ROWS_BITS-1:0] NUM_ROWS_RESET    = 11'd1;
   localparam logic [COLS_BITS-1:0] NUM_COLUMNS_RESET = 7'd64;

   typedef struct packed {
      logic first_row;
      logic has_left;
      logic has_right;
      logic last_col;
      logic done;
   } cell_flags_type;

endpackage

`default_nettype wire

// File: design/grid_min_path_sum.sv
// A cost transfer passes the cell stage and then the result register, and each cell reads two
// row-memory entries at once. One cost transfer per cycle unless a held result blocks the stage.
// The result register lets a new transfer in while a finished result waits on rsp_ready.
// Reset is synchronous: it sets num_rows to 1 and num_columns to 64 and restarts the grid.
// The row memory is not cleared; the first row of each grid ignores what it reads from it.
`default_nettype none

module grid_min_path_sum #(
   parameter int MAX_COLUMNS = gmps_pkg::DEF_MAX_COLUMNS,
   parameter int SUM_BITS    = gmps_pkg::DEF_SUM_BITS,
   parameter int COST_BITS   = gmps_pkg::DEF_COST_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [gmps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [gmps_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [COST_BITS-1:0]                req_cell_cost,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [SUM_BITS-1:0]                      rsp_cell_sum,
   output logic [SUM_BITS-1:0]                      rsp_best_total,
   output logic                                     rsp_grid_done
);

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   logic                     accept;
   logic [AW-1:0]            col_index;
   logic [AW-1:0]            right_index;
   gmps_pkg::cell_flags_type cell_flags;
   logic                     write_enable;
   logic [AW-1:0]            write_addr;
   logic [SUM_BITS-1:0]      write_data;
   logic [SUM_BITS-1:0]      old_here;
   logic [SUM_BITS-1:0]      old_right;

   assign accept = req_valid && req_ready;

   gmps_ctrl #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .col_index        (col_index),
      .right_index      (right_index),
      .cell_flags       (cell_flags)
   );

   gmps_row_mem #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .SUM_BITS    (SUM_BITS)
   ) u_row_mem (
      .clock        (clock),
      .write_enable (write_enable),
      .write_addr   (write_addr),
      .write_data   (write_data),
      .read_enable  (accept),
      .read_addr0   (col_index),
      .read_addr1   (right_index),
      .read_data0   (old_here),
      .read_data1   (old_right)
   );

   gmps_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .SUM_BITS    (SUM_BITS),
      .COST_BITS   (COST_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .cell_cost      (req_cell_cost),
      .cell_flags     (cell_flags),
      .col_index      (col_index),
      .old_here       (old_here),
      .old_right      (old_right),
      .rsp_ready      (rsp_ready),
      .req_ready      (req_ready),
      .write_enable   (write_enable),
      .write_addr     (write_addr),
      .write_data     (write_data),
      .rsp_valid      (rsp_valid),
      .rsp_cell_sum   (rsp_cell_sum),
      .rsp_best_total (rsp_best_total),
      .rsp_grid_done  (rsp_grid_done)
   );

endmodule

`default_nettype wire

// File: design/gmps_ctrl.sv
// Configuration registers and grid position counters.
`default_nettype none
`include "grid_min_path_sum_macros.svh"

module gmps_ctrl #(
   parameter int MAX_COLUMNS = gmps_pkg::DEF_MAX_COLUMNS,
   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
   localparam int CW = $clog2(MAX_COLUMNS + 1)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [gmps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [gmps_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  wire logic                                  accept,
   output logic [AW-1:0]                              col_index,
   output logic [AW-1:0]                              right_index,
   output gmps_pkg::cell_flags_type                   cell_flags
);

   logic [gmps_pkg::ROWS_BITS-1:0]      num_rows_ff, num_rows_in;
   logic [gmps_pkg::COLS_BITS-1:0]      num_columns_ff, num_columns_in;
   logic [AW-1:0]                       col_ff, col_in;
   logic [gmps_pkg::ROW_INDEX_BITS-1:0] row_ff, row_in;
   logic [gmps_pkg::ROWS_BITS-1:0]      eff_rows;
   logic [CW-1:0]                       eff_cols;
   logic [CW-1:0]                       col_plus;
   logic                                csr_hit;
   gmps_pkg::cell_flags_type            flags;

   always_comb begin
      if (num_rows_ff == '0) begin
         eff_rows = gmps_pkg::ROWS_BITS'(1);
      end else if (32'(num_rows_ff) > gmps_pkg::ROW_LIMIT) begin
         eff_rows = gmps_pkg::ROWS_BITS'(gmps_pkg::ROW_LIMIT);
      end else begin
         eff_rows = num_rows_ff;
      end

      if (num_columns_ff == '0) begin
         eff_cols = CW'(1);
      end else if (32'(num_columns_ff) > MAX_COLUMNS) begin
         eff_cols = CW'(MAX_COLUMNS);
      end else begin
         eff_cols = CW'(num_columns_ff);
      end

      col_plus        = CW'(col_ff) + CW'(1);
      flags.first_row = (row_ff == '0);
      flags.has_left  = (col_ff != '0);
      flags.has_right = (col_plus < eff_cols);
      flags.last_col  = (col_plus == eff_cols);
      flags.done      = flags.last_col &&
                        ((gmps_pkg::ROWS_BITS'(row_ff) + gmps_pkg::ROWS_BITS'(1)) >= eff_rows);

      csr_hit = csr_write_enable &&
                (csr_index == gmps_pkg::CSR_NUM_ROWS || csr_index == gmps_pkg::CSR_NUM_COLUMNS);

      num_rows_in    = num_rows_ff;
      num_columns_in = num_columns_ff;
      col_in         = col_ff;
      row_in         = row_ff;

      if (csr_write_enable && csr_index == gmps_pkg::CSR_NUM_ROWS) begin
         num_rows_in = csr_write_data;
      end
      if (csr_write_enable && csr_index == gmps_pkg::CSR_NUM_COLUMNS) begin
         num_columns_in = gmps_pkg::COLS_BITS'(csr_write_data);
      end

      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (flags.done) begin
            col_in = '0;
            row_in = '0;
         end else if (flags.last_col) begin
            col_in = '0;
            row_in = row_ff + gmps_pkg::ROW_INDEX_BITS'(1);
         end else begin
            col_in = AW'(col_plus);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff    <= gmps_pkg::NUM_ROWS_RESET;
         num_columns_ff <= gmps_pkg::NUM_COLUMNS_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
      end else begin
         num_rows_ff    <= num_rows_in;
         num_columns_ff <= num_columns_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
      end
   end

   assign col_index   = col_ff;
   assign right_index = col_ff + AW'(1);
   assign cell_flags  = flags;

   `GMPS_ASSERT(a_col_in_range, clock, reset, CW'(col_ff) < eff_cols, "Column index beyond row width")
   `GMPS_ASSERT(a_row_in_range, clock, reset, gmps_pkg::ROWS_BITS'(row_ff) < eff_rows, "Row index beyond grid height")
   `GMPS_ASSERT_ALWAYS(a_csr_restarts_grid, clock, csr_hit || reset |=> col_ff == '0 && row_ff == '0, "Grid position not restarted")

endmodule

`default_nettype wire

// File: design/gmps_row_mem.sv
// Row memory of previous-row sums with two registered read ports and write bypass.
`default_nettype none

module gmps_row_mem #(
   parameter int MAX_COLUMNS = gmps_pkg::DEF_MAX_COLUMNS,
   parameter int SUM_BITS    = gmps_pkg::DEF_SUM_BITS,
   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  wire logic                clock,
   input  wire logic                write_enable,
   input  wire logic [AW-1:0]       write_addr,
   input  wire logic [SUM_BITS-1:0] write_data,
   input  wire logic                read_enable,
   input  wire logic [AW-1:0]       read_addr0,
   input  wire logic [AW-1:0]       read_addr1,
   output logic [SUM_BITS-1:0]      read_data0,
   output logic [SUM_BITS-1:0]      read_data1
);

   logic [SUM_BITS-1:0] row_sums_ff [MAX_COLUMNS];
   logic [SUM_BITS-1:0] read_data0_ff;
   logic [SUM_BITS-1:0] read_data1_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         row_sums_ff[write_addr] <= write_data;
      end
   end

   // A sum written at the same edge as the read is passed straight through.
   always_ff @(posedge clock) begin
      if (read_enable) begin
         if (write_enable && write_addr == read_addr0) begin
            read_data0_ff <= write_data;
         end else begin
            read_data0_ff <= row_sums_ff[read_addr0];
         end
         if (write_enable && write_addr == read_addr1) begin
            read_data1_ff <= write_data;
         end else begin
            read_data1_ff <= row_sums_ff[read_addr1];
         end
      end
   end

   assign read_data0 = read_data0_ff;
   assign read_data1 = read_data1_ff;

endmodule

`default_nettype wire

// File: design/gmps_datapath.sv
// Cell stage and result register: neighbor minimum, saturating add, row minimum.
`default_nettype none
`include "grid_min_path_sum_macros.svh"

module gmps_datapath #(
   parameter int MAX_COLUMNS = gmps_pkg::DEF_MAX_COLUMNS,
   parameter int SUM_BITS    = gmps_pkg::DEF_SUM_BITS,
   parameter int COST_BITS   = gmps_pkg::DEF_COST_BITS,
   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
   localparam int ADD_BITS = ((SUM_BITS > COST_BITS) ? SUM_BITS : COST_BITS) + 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [COST_BITS-1:0]     cell_cost,
   input  wire gmps_pkg::cell_flags_type cell_flags,
   input  wire logic [AW-1:0]            col_index,
   input  wire logic [SUM_BITS-1:0]      old_here,
   input  wire logic [SUM_BITS-1:0]      old_right,
   input  wire logic                     rsp_ready,
   output logic                          req_ready,
   output logic                          write_enable,
   output logic [AW-1:0]                 write_addr,
   output logic [SUM_BITS-1:0]           write_data,
   output logic                          rsp_valid,
   output logic [SUM_BITS-1:0]           rsp_cell_sum,
   output logic [SUM_BITS-1:0]           rsp_best_total,
   output logic                          rsp_grid_done
);

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   logic                     stage_valid_ff, stage_valid_in;
   logic                     out_valid_ff, out_valid_in;
   logic [COST_BITS-1:0]     cost_ff;
   gmps_pkg::cell_flags_type flags_ff;
   logic [AW-1:0]            col_ff;
   logic [SUM_BITS-1:0]      left_old_ff, left_old_in;
   logic [SUM_BITS-1:0]      run_min_ff, run_min_in;
   logic [SUM_BITS-1:0]      out_sum_ff;
   logic [SUM_BITS-1:0]      out_best_ff;
   logic                     out_done_ff;
   logic                     advance;
   logic [SUM_BITS-1:0]      best;
   logic [ADD_BITS-1:0]      sum_wide;
   logic [SUM_BITS-1:0]      sum;
   logic [SUM_BITS-1:0]      row_min;

   always_comb begin
      advance   = stage_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready = !stage_valid_ff || advance;

      if (flags_ff.first_row) begin
         best = '0;
      end else begin
         best = old_here;
         if (flags_ff.has_left && left_old_ff < best) begin
            best = left_old_ff;
         end
         if (flags_ff.has_right && old_right < best) begin
            best = old_right;
         end
      end

      sum_wide = ADD_BITS'(best) + ADD_BITS'(cost_ff);
      sum      = (sum_wide > ADD_BITS'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(sum_wide);
      row_min  = (flags_ff.has_left && run_min_ff < sum) ? run_min_ff : sum;

      stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
      out_valid_in   = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      left_old_in    = advance ? old_here : left_old_ff;
      run_min_in     = advance ? row_min : run_min_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         left_old_ff    <= '0;
         run_min_ff     <= SUM_MAX;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         left_old_ff    <= left_old_in;
         run_min_ff     <= run_min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cost_ff  <= cell_cost;
         flags_ff <= cell_flags;
         col_ff   <= col_index;
      end
      if (advance) begin
         out_sum_ff  <= sum;
         out_best_ff <= flags_ff.done ? row_min : '0;
         out_done_ff <= flags_ff.done;
      end
   end

   assign write_enable   = advance;
   assign write_addr     = col_ff;
   assign write_data     = sum;
   assign rsp_valid      = out_valid_ff;
   assign rsp_cell_sum   = out_sum_ff;
   assign rsp_best_total = out_best_ff;
   assign rsp_grid_done  = out_done_ff;

   `GMPS_ASSERT(a_best_zero_unless_done, clock, reset, out_valid_ff && !out_done_ff |-> out_best_ff == '0, "Best total set on a cell that is not last")
   `GMPS_ASSERT(a_best_not_above_sum, clock, reset, out_valid_ff && out_done_ff |-> out_best_ff <= out_sum_ff, "Best total above the last cell sum")
   `GMPS_ASSERT(a_write_fills_output, clock, reset, write_enable |=> out_valid_ff && !stage_valid_ff || out_valid_ff, "Row write without a result")

endmodule

`default_nettype wire
